FILE: rtl/core/lepbg_pkg.sv
// Package for the LCG entropy pool byte generator.
// Holds LCG constants, command codes, controller/datapath command/status structs.
// No dependencies.
package lepbg_pkg;

  localparam int POOL_DEPTH_DEFAULT = 256;

  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_INC   = 32'd1013904223;
  localparam logic [31:0] LCG_RESET = 32'h1234_5678;
  localparam int          MIX_STRIDE = 13;
  localparam int          SEED_SPAN  = 24;

  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_SEED = 2'd2;

  localparam logic [1:0] LCG_HOLD      = 2'd0;
  localparam logic [1:0] LCG_STEP      = 2'd1;
  localparam logic [1:0] LCG_STEP_DATA = 2'd2;
  localparam logic [1:0] LCG_LOAD      = 2'd3;

  localparam logic [1:0] RD_PTR_NEXT = 2'd0;
  localparam logic [1:0] RD_IDX      = 2'd1;
  localparam logic [1:0] RD_FAR      = 2'd2;

  localparam logic [1:0] WA_PTR = 2'd0;
  localparam logic [1:0] WA_IDX = 2'd1;
  localparam logic [1:0] WA_FAR = 2'd2;

  localparam logic [2:0] WD_ZERO     = 3'd0;
  localparam logic [2:0] WD_READ     = 3'd1;
  localparam logic [2:0] WD_ADD      = 3'd2;
  localparam logic [2:0] WD_MIX_NEAR = 3'd3;
  localparam logic [2:0] WD_MIX_FAR  = 3'd4;
  localparam logic [2:0] WD_SEED     = 3'd5;

  typedef struct packed {
    logic [1:0] lcg_op;
    logic       ptr_adv;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wa_sel;
    logic [2:0] wd_sel;
    logic       data_cap;
    logic       mix_cap;
    logic       out_load;
    logic       idx_clr;
    logic       idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
  } dp_status_t;

  function automatic logic [31:0] lcg_step(input logic [31:0] v);
    return v * LCG_MUL + LCG_INC;
  endfunction

endpackage

FILE: rtl/core/lepbg_datapath.sv
// Datapath of the LCG entropy pool byte generator: LCG state, pool memory,
// pool pointer, pass index and output register. Driven by lepbg_ctrl.
// Depends on lepbg_pkg.
module lepbg_datapath import lepbg_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  data_byte,
  input  logic [31:0] seed_value,
  output dp_status_t  status,
  output logic [7:0]  random_byte
);

  localparam int AW = $clog2(POOL_DEPTH);

  logic [7:0]    mem [0:POOL_DEPTH-1];
  logic [31:0]   lcg;
  logic [31:0]   lcg_next;
  logic [AW-1:0] ptr;
  logic [AW-1:0] ptr_inc;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_far;
  logic [AW:0]   idx_sum;
  logic [4:0]    shift_cnt;
  logic [7:0]    data_q;
  logic [7:0]    mix_q;
  logic [7:0]    rd_q;
  logic [7:0]    read_result;
  logic [7:0]    mix_near;
  logic [31:0]   seed_word;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  assign ptr_inc = (ptr == AW'(POOL_DEPTH - 1)) ? '0 : ptr + AW'(1);
  assign idx_sum = {1'b0, idx} + (AW+1)'(MIX_STRIDE);
  assign idx_far = (idx_sum >= (AW+1)'(POOL_DEPTH)) ?
                   AW'(idx_sum - (AW+1)'(POOL_DEPTH)) : idx_sum[AW-1:0];
  assign status.idx_last = (idx == AW'(POOL_DEPTH - 1));

  assign read_result = rd_q ^ lcg[23:16];
  assign mix_near    = rd_q ^ lcg[23:16];
  assign seed_word   = lcg >> shift_cnt;

  always_comb begin
    case (cmd.lcg_op)
      LCG_STEP:      lcg_next = lcg_step(lcg);
      LCG_STEP_DATA: lcg_next = lcg_step(lcg ^ {24'd0, data_byte});
      LCG_LOAD:      lcg_next = seed_value;
      default:       lcg_next = lcg;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:  rd_addr = idx;
      RD_FAR:  rd_addr = idx_far;
      default: rd_addr = ptr_inc;
    endcase
  end

  always_comb begin
    case (cmd.wa_sel)
      WA_IDX:  wr_addr = idx;
      WA_FAR:  wr_addr = idx_far;
      default: wr_addr = ptr;
    endcase
  end

  always_comb begin
    case (cmd.wd_sel)
      WD_READ:     wr_data = read_result ^ lcg[15:8];
      WD_ADD:      wr_data = rd_q ^ data_q;
      WD_MIX_NEAR: wr_data = mix_near;
      WD_MIX_FAR:  wr_data = rd_q ^ mix_q;
      WD_SEED:     wr_data = seed_word[7:0];
      default:     wr_data = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg       <= LCG_RESET;
      ptr       <= '0;
      idx       <= '0;
      shift_cnt <= '0;
    end else begin
      lcg <= lcg_next;
      if (cmd.ptr_adv) begin
        ptr <= ptr_inc;
      end
      if (cmd.idx_clr) begin
        idx       <= '0;
        shift_cnt <= '0;
      end else if (cmd.idx_inc) begin
        idx       <= idx + AW'(1);
        shift_cnt <= (shift_cnt == 5'(SEED_SPAN - 1)) ? 5'd0 : shift_cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data_cap) begin
      data_q <= data_byte;
    end
    if (cmd.mix_cap) begin
      mix_q <= mix_near;
    end
    if (cmd.out_load) begin
      random_byte <= read_result;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/lepbg_ctrl.sv
// Controller of the LCG entropy pool byte generator: command decode, clearing,
// mix and seed passes, input ready and output valid. Drives lepbg_datapath.
// Depends on lepbg_pkg.
module lepbg_ctrl import lepbg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] command,
  input  logic       last_of_write,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RD_WB  = 3'd2;
  localparam logic [2:0] S_ADD_WB = 3'd3;
  localparam logic [2:0] S_MIX_RD = 3'd4;
  localparam logic [2:0] S_MIX_WI = 3'd5;
  localparam logic [2:0] S_MIX_WJ = 3'd6;
  localparam logic [2:0] S_SEED   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       mix_pending;
  logic       mix_pending_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next       = state;
    mix_pending_next = mix_pending;
    cmd              = '0;
    case (state)
      S_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_IDX;
        cmd.wd_sel = WD_ZERO;
        if (status.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_READ: begin
              cmd.lcg_op  = LCG_STEP;
              cmd.ptr_adv = 1'b1;
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = RD_PTR_NEXT;
              state_next  = S_RD_WB;
            end
            CMD_ADD: begin
              cmd.lcg_op       = LCG_STEP_DATA;
              cmd.ptr_adv      = 1'b1;
              cmd.rd_en        = 1'b1;
              cmd.rd_sel       = RD_PTR_NEXT;
              cmd.data_cap     = 1'b1;
              mix_pending_next = last_of_write;
              state_next       = S_ADD_WB;
            end
            CMD_SEED: begin
              cmd.lcg_op  = LCG_LOAD;
              cmd.idx_clr = 1'b1;
              state_next  = S_SEED;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_RD_WB: begin
        if (out_free) begin
          cmd.wr_en    = 1'b1;
          cmd.wa_sel   = WA_PTR;
          cmd.wd_sel   = WD_READ;
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ADD_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_PTR;
        cmd.wd_sel = WD_ADD;
        if (mix_pending) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_MIX_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MIX_RD: begin
        cmd.lcg_op = LCG_STEP;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_next = S_MIX_WI;
      end
      S_MIX_WI: begin
        cmd.wr_en   = 1'b1;
        cmd.wa_sel  = WA_IDX;
        cmd.wd_sel  = WD_MIX_NEAR;
        cmd.mix_cap = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_FAR;
        state_next  = S_MIX_WJ;
      end
      S_MIX_WJ: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_FAR;
        cmd.wd_sel = WD_MIX_FAR;
        if (status.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_MIX_RD;
        end
      end
      S_SEED: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_IDX;
        cmd.wd_sel = WD_SEED;
        cmd.lcg_op = LCG_STEP;
        if (status.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      mix_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      mix_pending <= mix_pending_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/lcg_entropy_pool_byte_generator.sv
// Top level of the LCG entropy pool byte generator.
// Joins lepbg_ctrl and lepbg_datapath; depends on lepbg_pkg.
//
// Usage:
//   Input words arrive on the s_axis channel: tuser carries the command
//   (read, add entropy, reseed), tdata the entropy byte and the 32-bit seed,
//   tlast marks the final entropy byte of a write. Read commands return one
//   random byte on the m_axis channel; add and reseed return nothing, and an
//   unused command code is taken and dropped.
//   Sequences, with N = POOL_DEPTH:
//     read    accept, then a write-back that loads the output register once free
//     add     accept and write-back, then a pool mix when tlast is set
//             (one memory read-modify-write pair per entry)
//     reseed  all N entries rewritten, one pool entry written per cycle
//     unused  accepted and dropped in the idle state
//   The pool is a single memory with one write and one read port, which
//   sets these sequences. After rst the block runs a clearing pass over
//   all N entries with s_axis_tready low. A stalled receiver holds the
//   result in the output register; a further read waits in its write-back
//   state, taking no input, until the register empties; add and reseed never wait.
module lcg_entropy_pool_byte_generator import lepbg_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // data_byte[7:0], seed_value[39:8]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // random_byte[7:0]
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  lepbg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .command       (s_axis_tuser),
    .last_of_write (s_axis_tlast),
    .in_ready      (s_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .status        (dp_status),
    .cmd           (dp_cmd)
  );

  lepbg_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .data_byte   (s_axis_tdata[7:0]),
    .seed_value  (s_axis_tdata[39:8]),
    .status      (dp_status),
    .random_byte (m_axis_tdata)
  );

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready during pool clearing pass");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_READ)) |=> !s_axis_tready)
    else $error("input taken during read write-back");

  a_seed_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_SEED)) |=> !s_axis_tready)
    else $error("input taken during seed pass");

endmodule
